>>> design/priority_round_robin_task_scheduler_macros.svh
// Assertion macros used by the scheduler checker
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication
`define PRRTS_ASSERT_NOW(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("scheduler check failed");

// next-cycle implication
`define PRRTS_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("scheduler check failed");

`endif

>>> design/prrts_pkg.sv
// Shared types and codes of the task scheduler
package prrts_pkg;

  typedef enum logic [1:0] {
    REQ_SCHEDULE = 2'd0,
    REQ_ADD      = 2'd1,
    REQ_SUSPEND  = 2'd2,
    REQ_SIGNAL   = 2'd3
  } req_code_t;

  localparam logic [1:0] OUTCOME_NONE    = 2'd0;
  localparam logic [1:0] OUTCOME_OK      = 2'b01;
  localparam logic [1:0] OUTCOME_TIMEOUT = 2'd2;

  localparam int unsigned CFG_BITS = 4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ticks;
    logic [31:0] saved_sp;
    logic [3:0]  task_id;
    logic [2:0]  task_priority;
    logic [31:0] wait_until;
    logic        wait_on_signal;
    logic        signal_avail;
  } req_t;

  typedef struct packed {
    logic [3:0]  next_task;
    logic [31:0] next_sp;
    logic        privileged;
    logic [1:0]  wait_result;
    logic        none_ready;
  } res_t;

endpackage

>>> design/prrts_wait_eval.sv
// Shared wait evaluation unit: deadline compare and signal check for one task
module prrts_wait_eval import prrts_pkg::*; #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic [TICK_BITS-1:0] now,
  input  logic [TICK_BITS-1:0] deadline,
  input  logic                 sig_wait,
  input  logic                 sig_avail,
  input  logic [1:0]           outcome,
  output logic                 ready,
  output logic [TICK_BITS-1:0] deadline_next,
  output logic                 sig_wait_next,
  output logic [1:0]           outcome_next
);

  always_comb begin
    ready         = 1'b1;
    deadline_next = deadline;
    sig_wait_next = sig_wait;
    outcome_next  = outcome;
    if (deadline > now) begin
      if (sig_wait && sig_avail) begin
        outcome_next  = OUTCOME_OK;
        sig_wait_next = 1'b0;
        deadline_next = '0;
      end else begin
        ready = 1'b0;
      end
    end else if (deadline != '0) begin
      if (sig_wait) begin
        outcome_next  = OUTCOME_TIMEOUT;
        sig_wait_next = 1'b0;
      end
      deadline_next = '0;
    end
  end

endmodule

>>> design/priority_round_robin_task_scheduler.sv
// Top level of the fixed-priority round-robin task scheduler
//
// Command channel: req is taken at a clock edge with start high and busy low.
// Every item gives exactly one result on result, flagged by done for one
// cycle; the receiver takes it at that edge and cannot hold it off.
// Config: cfg_we writes cfg_wdata into the privileged level count; the user
// must write it only while idle, the block itself does not enforce this.
// Add, suspend and signal items show done in the cycle after transfer.
// A schedule item walks the waiting lists one task per cycle through
// the single wait evaluation unit, then requeues the outgoing task with
// the same unit, then picks the next task.
// busy is high from transfer until the cycle that shows done.
// Reset (rst, synchronous): no running task, all slots free, all lists
// empty, privileged level count 4. Slot payload is not cleared; a slot is
// read only after an add has written it.
module priority_round_robin_task_scheduler import prrts_pkg::*; #(
  parameter int unsigned TASK_SLOTS  = 16,
  parameter int unsigned PRIO_LEVELS = 8,
  parameter int unsigned TICK_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  req_t                req,
  output logic                done,
  output res_t                result,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int unsigned SW = $clog2(TASK_SLOTS + 1);
  localparam int unsigned IW = $clog2(TASK_SLOTS);
  localparam int unsigned PW = $clog2(PRIO_LEVELS);
  localparam logic [SW-1:0] NIL = SW'(TASK_SLOTS);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WALK = 5'b00010,
    ST_REQ  = 5'b00100,
    ST_PICK = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state;

  logic [31:0]          stack_ptr [TASK_SLOTS];
  logic [PW-1:0]        prio      [TASK_SLOTS];
  logic [TICK_BITS-1:0] deadline  [TASK_SLOTS];
  logic                 sig_wait  [TASK_SLOTS];
  logic                 sig_avail [TASK_SLOTS];
  logic [1:0]           outcome   [TASK_SLOTS];
  logic [SW-1:0]        link      [TASK_SLOTS];
  logic                 used      [TASK_SLOTS];
  logic [SW-1:0]        rdy_head  [PRIO_LEVELS];
  logic [SW-1:0]        rdy_tail  [PRIO_LEVELS];
  logic [SW-1:0]        wt_head   [PRIO_LEVELS];
  logic [SW-1:0]        wt_tail   [PRIO_LEVELS];

  logic [PW-1:0]        p;
  logic [SW-1:0]        cur;
  logic [SW-1:0]        prev;
  logic                 run_valid;
  logic [IW-1:0]        run_slot;
  logic [CFG_BITS-1:0]  plevels;
  logic [TICK_BITS-1:0] now_r;
  logic [31:0]          sp_r;

  // input conversions
  logic [TICK_BITS+31:0] now_x, until_x;
  logic [TICK_BITS-1:0]  now_in, until_in;
  logic [SW+3:0]         id_x;
  logic                  id_ok;
  logic [IW-1:0]         id_i;
  logic [PW+2:0]         pr_x;
  logic [PW-1:0]         pr_sat;

  always_comb begin
    now_x    = (TICK_BITS+32)'(req.now_ticks);
    until_x  = (TICK_BITS+32)'(req.wait_until);
    now_in   = now_x[TICK_BITS-1:0];
    until_in = until_x[TICK_BITS-1:0];
    id_x     = (SW+4)'(req.task_id);
    id_ok    = id_x < (SW+4)'(TASK_SLOTS);
    id_i     = id_x[IW-1:0];
    pr_x     = (PW+3)'(req.task_priority);
    pr_sat   = (pr_x >= (PW+3)'(PRIO_LEVELS)) ? PW'(PRIO_LEVELS - 1) : pr_x[PW-1:0];
  end

  // shared evaluation unit: walked slot or outgoing running slot
  logic [IW-1:0]        ev_i;
  logic                 ev_ready;
  logic [TICK_BITS-1:0] ev_deadline;
  logic                 ev_sig_wait;
  logic [1:0]           ev_outcome;

  assign ev_i = (state == ST_WALK) ? cur[IW-1:0] : run_slot;

  prrts_wait_eval #(.TICK_BITS(TICK_BITS)) u_eval (
    .now           (now_r),
    .deadline      (deadline[ev_i]),
    .sig_wait      (sig_wait[ev_i]),
    .sig_avail     (sig_avail[ev_i]),
    .outcome       (outcome[ev_i]),
    .ready         (ev_ready),
    .deadline_next (ev_deadline),
    .sig_wait_next (ev_sig_wait),
    .outcome_next  (ev_outcome)
  );

  // highest-priority (lowest-numbered) non-empty ready list
  logic          pick_found;
  logic [PW-1:0] pick_p;

  always_comb begin
    pick_found = 1'b0;
    pick_p     = '0;
    for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
      if (rdy_head[i] != NIL) begin
        pick_found = 1'b1;
        pick_p     = PW'(i);
      end
    end
  end

  logic [SW-1:0] pick_s;
  logic [SW-1:0] cur_nxt;
  logic [PW-1:0] run_p;

  assign pick_s  = rdy_head[pick_p];
  assign cur_nxt = link[cur[IW-1:0]];
  assign run_p   = prio[run_slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      run_valid <= 1'b0;
      plevels   <= CFG_BITS'(4);
      p         <= '0;
      cur       <= NIL;
      prev      <= NIL;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        used[i] <= 1'b0;
      end
      for (int i = 0; i < PRIO_LEVELS; i++) begin
        rdy_head[i] <= NIL;
        rdy_tail[i] <= NIL;
        wt_head[i]  <= NIL;
        wt_tail[i]  <= NIL;
      end
    end else begin
      if (cfg_we) begin
        plevels <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            now_r <= now_in;
            sp_r  <= req.saved_sp;
            case (req.req_type)
              REQ_SCHEDULE: begin
                p     <= '0;
                cur   <= wt_head[0];
                prev  <= NIL;
                state <= ST_WALK;
              end
              REQ_ADD: begin
                state <= ST_OUT;
                if (id_ok && !used[id_i]) begin
                  used[id_i]      <= 1'b1;
                  stack_ptr[id_i] <= req.saved_sp;
                  prio[id_i]      <= pr_sat;
                  deadline[id_i]  <= '0;
                  sig_wait[id_i]  <= 1'b0;
                  sig_avail[id_i] <= 1'b0;
                  outcome[id_i]   <= OUTCOME_NONE;
                  link[id_i]      <= NIL;
                  if (rdy_head[pr_sat] == NIL) begin
                    rdy_head[pr_sat] <= SW'(id_i);
                  end else begin
                    link[rdy_tail[pr_sat][IW-1:0]] <= SW'(id_i);
                  end
                  rdy_tail[pr_sat] <= SW'(id_i);
                end
              end
              REQ_SUSPEND: begin
                state <= ST_OUT;
                if (run_valid) begin
                  deadline[run_slot] <= until_in;
                  sig_wait[run_slot] <= req.wait_on_signal;
                end
              end
              REQ_SIGNAL: begin
                state <= ST_OUT;
                if (id_ok) begin
                  sig_avail[id_i] <= req.signal_avail;
                end
              end
              default: state <= ST_OUT;
            endcase
          end
        end
        ST_WALK: begin
          if (cur == NIL) begin
            if (p == PW'(PRIO_LEVELS - 1)) begin
              state <= ST_REQ;
            end else begin
              p    <= p + 1'b1;
              cur  <= wt_head[p + 1'b1];
              prev <= NIL;
            end
          end else begin
            deadline[cur[IW-1:0]] <= ev_deadline;
            sig_wait[cur[IW-1:0]] <= ev_sig_wait;
            outcome[cur[IW-1:0]]  <= ev_outcome;
            if (ev_ready) begin
              // unlink from waiting list, append to ready list of same level
              if (prev == NIL) begin
                wt_head[p] <= cur_nxt;
              end else begin
                link[prev[IW-1:0]] <= cur_nxt;
              end
              if (wt_tail[p] == cur) begin
                wt_tail[p] <= prev;
              end
              if (rdy_head[p] == NIL) begin
                rdy_head[p] <= cur;
              end else begin
                link[rdy_tail[p][IW-1:0]] <= cur;
              end
              rdy_tail[p]        <= cur;
              link[cur[IW-1:0]]  <= NIL;
            end else begin
              prev <= cur;
            end
            cur <= cur_nxt;
          end
        end
        ST_REQ: begin
          if (run_valid) begin
            stack_ptr[run_slot] <= sp_r;
            deadline[run_slot]  <= ev_deadline;
            sig_wait[run_slot]  <= ev_sig_wait;
            outcome[run_slot]   <= ev_outcome;
            link[run_slot]      <= NIL;
            if (ev_ready) begin
              if (rdy_head[run_p] == NIL) begin
                rdy_head[run_p] <= SW'(run_slot);
              end else begin
                link[rdy_tail[run_p][IW-1:0]] <= SW'(run_slot);
              end
              rdy_tail[run_p] <= SW'(run_slot);
            end else begin
              if (wt_head[run_p] == NIL) begin
                wt_head[run_p] <= SW'(run_slot);
              end else begin
                link[wt_tail[run_p][IW-1:0]] <= SW'(run_slot);
              end
              wt_tail[run_p] <= SW'(run_slot);
            end
            run_valid <= 1'b0;
          end
          state <= ST_PICK;
        end
        ST_PICK: begin
          if (pick_found) begin
            rdy_head[pick_p] <= link[pick_s[IW-1:0]];
            if (link[pick_s[IW-1:0]] == NIL) begin
              rdy_tail[pick_p] <= NIL;
            end
            run_slot  <= pick_s[IW-1:0];
            run_valid <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  logic [IW+3:0] run_x;
  assign run_x = (IW+4)'(run_slot);

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_OUT);

  always_comb begin
    result = '0;
    result.none_ready = 1'b1;
    if (run_valid) begin
      result.next_task   = run_x[3:0];
      result.next_sp     = stack_ptr[run_slot];
      result.privileged  = (PW+5)'(prio[run_slot]) < (PW+5)'(plevels);
      result.wait_result = outcome[run_slot];
      result.none_ready  = 1'b0;
    end
  end

endmodule

>>> design/prrts_checker.sv
// Port-level checks of the task scheduler and their bind
`include "priority_round_robin_task_scheduler_macros.svh"

module prrts_checker import prrts_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input res_t result
);

  `PRRTS_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `PRRTS_ASSERT_NOW(a_done_in_busy, done, busy)
  `PRRTS_ASSERT_NXT(a_done_single, done, !done && !busy)
  `PRRTS_ASSERT_NOW(a_none_zero, done && result.none_ready,
                    result.next_task == 4'd0 && result.next_sp == 32'd0)

endmodule

bind priority_round_robin_task_scheduler prrts_checker u_prrts_checker (.*);

>>> tb/sv/tb.sv
// Self-checking testbench for the priority round-robin task scheduler
`timescale 1ns / 1ps

module tb;
  import prrts_pkg::*;

  localparam int NSLOT = 16;
  localparam int NPRIO = 8;
  localparam logic [4:0] NIL = 5'd16;
  localparam int LIMIT = 2000000;
  localparam int RQW = $bits(req_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  res_t result;
  logic cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  priority_round_robin_task_scheduler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler state mirror
  logic [3:0] priv_lvls;
  logic run_ok;
  logic [3:0] run_slot;
  logic used[NSLOT];
  logic [31:0] sp_m[NSLOT];
  logic [2:0] prio_m[NSLOT];
  logic [31:0] dl_m[NSLOT];
  logic sw_m[NSLOT];
  logic sa_m[NSLOT];
  logic [1:0] oc_m[NSLOT];
  logic [4:0] lnk[NSLOT];
  logic [4:0] rhd[NPRIO], rtl[NPRIO], whd[NPRIO], wtl[NPRIO];

  res_t sched_q[$];
  int errors = 0;
  int cycles = 0;

  task automatic mirror_reset();
    priv_lvls = 4'd4;
    run_ok = 1'b0;
    run_slot = '0;
    for (int i = 0; i < NSLOT; i++) begin
      used[i] = 1'b0; sp_m[i] = '0; prio_m[i] = '0; dl_m[i] = '0;
      sw_m[i] = 1'b0; sa_m[i] = 1'b0; oc_m[i] = OUTCOME_NONE; lnk[i] = NIL;
    end
    for (int p = 0; p < NPRIO; p++) begin
      rhd[p] = NIL; rtl[p] = NIL; whd[p] = NIL; wtl[p] = NIL;
    end
  endtask

  task automatic push_ready(int p, int s);
    lnk[s] = NIL;
    if (rhd[p] == NIL) rhd[p] = s[4:0];
    else lnk[rtl[p][3:0]] = s[4:0];
    rtl[p] = s[4:0];
  endtask

  task automatic push_wait(int p, int s);
    lnk[s] = NIL;
    if (whd[p] == NIL) whd[p] = s[4:0];
    else lnk[wtl[p][3:0]] = s[4:0];
    wtl[p] = s[4:0];
  endtask

  function automatic logic wake_check(int s, logic [31:0] now);
    if (dl_m[s] > now) begin
      if (!sw_m[s] || !sa_m[s]) return 1'b0;
      oc_m[s] = OUTCOME_OK;
      sw_m[s] = 1'b0;
      dl_m[s] = '0;
    end else if (dl_m[s] != 0) begin
      if (sw_m[s]) begin
        oc_m[s] = OUTCOME_TIMEOUT;
        sw_m[s] = 1'b0;
      end
      dl_m[s] = '0;
    end
    return 1'b1;
  endfunction

  task automatic run_schedule(logic [31:0] sp, logic [31:0] now);
    int prv, cur, nxt, g;
    for (int p = 0; p < NPRIO; p++) begin
      prv = int'(NIL); cur = int'(whd[p]); g = 0;
      while (cur < NSLOT && g < NSLOT) begin
        nxt = int'(lnk[cur]);
        g++;
        if (wake_check(cur, now)) begin
          if (prv == int'(NIL)) whd[p] = nxt[4:0];
          else lnk[prv] = nxt[4:0];
          if (int'(wtl[p]) == cur) wtl[p] = prv[4:0];
          push_ready(p, cur);
        end else prv = cur;
        cur = nxt;
      end
    end
    if (run_ok) begin
      sp_m[run_slot] = sp;
      if (wake_check(int'(run_slot), now))
        push_ready(int'(prio_m[run_slot]), int'(run_slot));
      else push_wait(int'(prio_m[run_slot]), int'(run_slot));
      run_ok = 1'b0;
    end
    for (int p = 0; p < NPRIO; p++) begin
      if (rhd[p] != NIL) begin
        run_slot = rhd[p][3:0];
        rhd[p] = lnk[run_slot];
        if (rhd[p] == NIL) rtl[p] = NIL;
        run_ok = 1'b1;
        break;
      end
    end
  endtask

  task automatic predict_item(req_t r);
    res_t e;
    case (req_code_t'(r.req_type))
      REQ_SCHEDULE: run_schedule(r.saved_sp, r.now_ticks);
      REQ_ADD: begin
        if (!used[r.task_id]) begin
          used[r.task_id] = 1'b1; sp_m[r.task_id] = r.saved_sp;
          prio_m[r.task_id] = r.task_priority; dl_m[r.task_id] = '0;
          sw_m[r.task_id] = 1'b0; sa_m[r.task_id] = 1'b0;
          oc_m[r.task_id] = OUTCOME_NONE;
          push_ready(int'(r.task_priority), int'(r.task_id));
        end
      end
      REQ_SUSPEND: begin
        if (run_ok) begin
          dl_m[run_slot] = r.wait_until;
          sw_m[run_slot] = r.wait_on_signal;
        end
      end
      default: sa_m[r.task_id] = r.signal_avail;
    endcase
    e = '0;
    if (run_ok) begin
      e.next_task = run_slot;
      e.next_sp = sp_m[run_slot];
      e.privileged = ({1'b0, prio_m[run_slot]} < priv_lvls);
      e.wait_result = oc_m[run_slot];
    end else e.none_ready = 1'b1;
    sched_q.push_back(e);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (sched_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = sched_q.pop_front();
        if (result.none_ready !== e.none_ready) begin
          $error("none_ready exp %0d got %0d", e.none_ready, result.none_ready); errors++;
        end
        if (result.next_task !== e.next_task) begin
          $error("next_task exp %0d got %0d", e.next_task, result.next_task); errors++;
        end
        if (result.next_sp !== e.next_sp) begin
          $error("next_sp exp %h got %h", e.next_sp, result.next_sp); errors++;
        end
        if (result.privileged !== e.privileged) begin
          $error("privileged exp %0d got %0d", e.privileged, result.privileged); errors++;
        end
        if (result.wait_result !== e.wait_result) begin
          $error("wait_result exp %0d got %0d", e.wait_result, result.wait_result); errors++;
        end
      end
    end
  end

  bit gaps_on = 1'b1;

  // start stays high until busy is seen low again; the block ignores start while busy anyway
  task automatic send_item(req_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    repeat (gap + 1) @(posedge clk);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(r);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (sched_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_priv(logic [3:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    priv_lvls = v;
  endtask

  function automatic req_t mk(req_code_t t, int unsigned now, int unsigned sp,
                              int unsigned id, int unsigned pr, int unsigned wu,
                              int unsigned ws, int unsigned sa);
    req_t r;
    r.req_type = t; r.now_ticks = now; r.saved_sp = sp; r.task_id = id[3:0];
    r.task_priority = pr[2:0]; r.wait_until = wu; r.wait_on_signal = ws[0];
    r.signal_avail = sa[0];
    return r;
  endfunction

  function automatic req_t rand_item(int bias);
    req_t r;
    int k;
    r = req_t'(RQW'({$urandom, $urandom, $urandom, $urandom}));
    k = $urandom_range(0, 99);
    // schedules most often, and with bias small tick windows so deadlines really expire
    if (k < 45) r.req_type = REQ_SCHEDULE;
    else if (k < 60) r.req_type = REQ_ADD;
    else if (k < 80) r.req_type = REQ_SUSPEND;
    else r.req_type = REQ_SIGNAL;
    if (bias != 0) begin
      r.now_ticks = $urandom_range(0, 300);
      r.wait_until = $urandom_range(0, 300);
    end
    return r;
  endfunction

  task automatic test_directed();
    send_item(mk(REQ_SCHEDULE, 0, 32'h1111, 0, 0, 0, 0, 0));
    send_item(mk(REQ_SUSPEND, 0, 0, 0, 0, 5, 1, 0));
    send_item(mk(REQ_ADD, 0, 32'hFFFF_FFFF, 15, 7, 0, 0, 0));
    send_item(mk(REQ_ADD, 0, 32'h0, 0, 0, 0, 0, 0));
    send_item(mk(REQ_ADD, 0, 32'h1234, 0, 3, 0, 0, 0));
    send_item(mk(REQ_ADD, 0, 32'hA5A5, 3, 0, 0, 0, 0));
    send_item(mk(REQ_SCHEDULE, 10, 32'hDEAD, 0, 0, 0, 0, 0));
    send_item(mk(REQ_SUSPEND, 10, 0, 0, 0, 32'hFFFF_FFFF, 1, 0));
    send_item(mk(REQ_SCHEDULE, 11, 32'hBEEF, 0, 0, 0, 0, 0));
    send_item(mk(REQ_SIGNAL, 11, 0, 0, 0, 0, 0, 1));
    send_item(mk(REQ_SCHEDULE, 12, 32'hC0DE, 0, 0, 0, 0, 0));
    send_item(mk(REQ_SUSPEND, 12, 0, 0, 0, 20, 1, 0));
    send_item(mk(REQ_SIGNAL, 12, 0, 3, 0, 0, 0, 0));
    send_item(mk(REQ_SCHEDULE, 13, 32'h1, 0, 0, 0, 0, 0));
    send_item(mk(REQ_SCHEDULE, 25, 32'h2, 0, 0, 0, 0, 0));
    send_item(mk(REQ_SUSPEND, 30, 0, 0, 0, 40, 0, 1));
    send_item(mk(REQ_SCHEDULE, 30, 32'h3, 0, 0, 0, 0, 0));
    send_item(mk(REQ_SCHEDULE, 32'hFFFF_FFFF, 32'h4, 0, 0, 0, 0, 0));
    send_item(mk(REQ_SIGNAL, 0, 0, 9, 0, 0, 0, 1));
    send_item(mk(REQ_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int n, int bias);
    for (int i = 0; i < n; i++) send_item(rand_item(bias));
  endtask

  task automatic test_quiesce();
    drain();
    gaps_on = 1'b0;
    test_random(60, 1);
    gaps_on = 1'b1;
  endtask

  initial begin
    mirror_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_priv(4'd0);
    test_random(400, 1);
    write_priv(4'd8);
    test_quiesce();
    test_random(400, 0);
    write_priv(4'd15);
    test_random(400, 1);
    write_priv(4'd3);
    test_random(600, 1);
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && sched_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
